@@ hdl/wve_pkg.sv @@
// ----------------------------------------------------------------------------
// wve_pkg: shared types and constants of the windowed velocity estimator
// Holds the history depth, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package wve_pkg;

	localparam int HistDepth = 32;
	localparam int HistAw = $clog2(HistDepth);
	localparam int CntW = $clog2(HistDepth + 1);
	localparam int EntryW = 128;
	localparam logic [31:0] WindowReset = 32'd100000;
	localparam logic [19:0] UsPerSec = 20'd1000000;

	// Velocity numerator magnitude: 33-bit difference times 10^6 fits in 53 bits.
	localparam int NumW = 54;
	// Sum of up to HistDepth signed 32-bit velocities.
	localparam int SumW = 32 + CntW + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_PUSH,
		ST_EVRD,
		ST_EVWAIT,
		ST_EVCHK,
		ST_SUMRD,
		ST_SUMWAIT,
		ST_SUMACC,
		ST_MDIV,
		ST_OUT
	} wve_state_t;

endpackage

@@ hdl/wve_ram.sv @@
// ----------------------------------------------------------------------------
// wve_ram: generic single-port-write, single-port-read RAM
// Synchronous write, registered read.
// ----------------------------------------------------------------------------
module wve_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/windowed_velocity_estimator.sv @@
// ----------------------------------------------------------------------------
// windowed_velocity_estimator: finite-difference velocity with window mean
// Estimates per-axis velocity from timestamped positions and averages it.
// ----------------------------------------------------------------------------
// Position samples enter as s_axis words (stamp and three Q16.16 axes).
// The first sample after reset is only stored and a sample whose time
// step is not positive is dropped; each other one gives one m_axis word.
// The window register is written on cfg_valid/cfg_ready while idle.
// A shared 54-bit restoring divider (one bit a cycle) does all six
// divisions, one 20x33 multiplier scales the differences. With n live
// entries after the push and e evicted by age (n+e <= 32), each of the
// n+e entries is read, waited on for the registered RAM read, then
// checked or summed; the next sample is taken once the word enters the
// output register. A first sample is only pushed; a dropped one leaves the block idle.
// s_axis_tready is low while a sample is in work. A finished word waits in
// the output register; a stalled receiver holds it unchanged and stops
// the block only once the next result is ready to be written.
// Reset clears the count, head and previous sample, not the RAM.
// ----------------------------------------------------------------------------
module windowed_velocity_estimator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // stamp_us, pos_x, pos_y, pos_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [223:0] m_axis_tdata   // out_stamp_us, out_pos_x/y/z, vel_x/y/z
);
	import wve_pkg::*;

	wve_state_t state_q, state_d;

	logic [31:0]       window_q;
	logic [HistAw-1:0] head_q;
	logic [CntW-1:0]   count_q;
	logic [31:0]       prev_stamp_q;
	logic [31:0]       prev_pos_q [3];

	logic [31:0]       stamp_q;
	logic [31:0]       pos_q [3];
	logic [31:0]       dt_q;
	logic [1:0]        axis_q;
	logic [31:0]       vel_q [3];
	logic [31:0]       mean_q [3];
	logic [SumW-1:0]   sum_q [3];
	logic [HistAw-1:0] walk_q;
	logic [CntW-1:0]   walk_cnt_q;

	// Shared divider: quotient/remainder restoring, one bit per cycle.
	logic [NumW-1:0]   dnum_q;
	logic [NumW-1:0]   drem_q;
	logic [NumW-1:0]   dden_q;
	logic              dneg_q;
	logic [5:0]        dbit_q;

	logic [223:0]      out_q;
	logic              out_valid_q;

	logic              ram_we;
	logic [HistAw-1:0] ram_waddr, ram_raddr;
	logic [EntryW-1:0] ram_wdata, ram_rdata;

	wve_ram #(.Width(EntryW), .Depth(HistDepth)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	logic in_fire;
	logic out_load;
	logic [31:0] in_stamp;
	logic [31:0] in_dt;
	logic [32:0] diff;
	logic        diff_neg;
	logic [32:0] diff_mag;
	logic [NumW-1:0] prod;
	logic [NumW-1:0] rem_sh;
	logic        rem_ge;
	logic [NumW-1:0] qinc;
	logic [32:0] qsat;
	logic [31:0] qres;
	logic [31:0] age;
	logic        too_old;
	logic [HistAw-1:0] slot;

	function automatic logic [SumW-1:0] sum_mag_next(input logic [SumW-1:0] s);
		return s[SumW-1] ? (SumW'(0) - s) : s;
	endfunction

	function automatic logic sum_neg_next(input logic [SumW-1:0] s);
		return s[SumW-1];
	endfunction

	assign in_stamp = s_axis_tdata[31:0];
	assign in_dt = in_stamp - prev_stamp_q;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_q;

	// The output register takes a new word once the previous one has gone.
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	assign diff = {pos_q[axis_q][31], pos_q[axis_q]} - {prev_pos_q[axis_q][31], prev_pos_q[axis_q]};
	assign diff_neg = diff[32];
	assign diff_mag = diff_neg ? (33'd0 - diff) : diff;
	assign prod = NumW'(diff_mag) * NumW'(UsPerSec);

	assign rem_sh = {drem_q[NumW-2:0], dnum_q[NumW-1]};
	assign rem_ge = rem_sh >= dden_q;

	// The quotient register holds the rounded magnitude once the divider ends.
	assign qinc = dnum_q;
	always_comb begin
		if (!dneg_q) begin
			qsat = (qinc > NumW'(32'h7fffffff)) ? 33'h07fffffff : {1'b0, qinc[31:0]};
		end else begin
			qsat = (qinc > NumW'(33'h080000000)) ? 33'h080000000 : {1'b0, qinc[31:0]};
		end
		qres = dneg_q ? (32'd0 - qsat[31:0]) : qsat[31:0];
	end

	assign age = stamp_q - ram_rdata[31:0];
	assign too_old = !age[31] && (age > window_q);

	assign slot = HistAw'((CntW+1)'(head_q) + (CntW+1)'(count_q)) ;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = slot;
		ram_wdata = {vel_q[2], vel_q[1], vel_q[0], stamp_q};
		ram_raddr = walk_q;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (count_q == '0) begin
						state_d = ST_PUSH;
					end else if (!in_dt[31] && in_dt != '0) begin
						state_d = ST_MUL;
					end
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (dbit_q == 6'd0) begin
					state_d = (axis_q == 2'd2) ? ST_PUSH : ST_MUL;
				end
			end
			ST_PUSH: begin
				ram_we = 1'b1;
				if (count_q == CntW'(HistDepth)) begin
					ram_waddr = head_q;
				end
				state_d = (walk_cnt_q == '1) ? ST_IDLE : ST_EVRD;
			end
			ST_EVRD: state_d = ST_EVWAIT;
			ST_EVWAIT: state_d = ST_EVCHK;
			ST_EVCHK: state_d = too_old ? ST_EVRD : ST_SUMRD;
			ST_SUMRD: state_d = ST_SUMWAIT;
			ST_SUMWAIT: state_d = ST_SUMACC;
			ST_SUMACC: state_d = (walk_cnt_q == CntW'(1)) ? ST_MDIV : ST_SUMRD;
			ST_MDIV: begin
				if (dbit_q == 6'd0 && axis_q == 2'd2) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: state_d = out_load ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WindowReset;
			head_q <= '0;
			count_q <= '0;
			prev_stamp_q <= '0;
			prev_pos_q[0] <= '0;
			prev_pos_q[1] <= '0;
			prev_pos_q[2] <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_PUSH: begin
					if (count_q == CntW'(HistDepth)) begin
						head_q <= HistAw'((CntW+1)'(head_q) + 1'b1);
					end else begin
						count_q <= count_q + 1'b1;
					end
					prev_stamp_q <= stamp_q;
					prev_pos_q <= pos_q;
				end
				ST_EVCHK: begin
					if (too_old) begin
						head_q <= HistAw'((CntW+1)'(head_q) + 1'b1);
						count_q <= count_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					stamp_q <= in_stamp;
					pos_q[0] <= s_axis_tdata[63:32];
					pos_q[1] <= s_axis_tdata[95:64];
					pos_q[2] <= s_axis_tdata[127:96];
					dt_q <= in_dt;
					axis_q <= 2'd0;
					vel_q[0] <= '0;
					vel_q[1] <= '0;
					vel_q[2] <= '0;
					// All ones marks the first sample: no walk and no result.
					walk_cnt_q <= (count_q == '0) ? '1 : '0;
				end
			end
			ST_MUL: begin
				// Rounding: magnitude plus half the divisor, then divide.
				dnum_q <= prod + NumW'(dt_q[31:1]);
				dden_q <= NumW'(dt_q);
				drem_q <= '0;
				dneg_q <= diff_neg;
				dbit_q <= 6'(NumW);
			end
			ST_DIV, ST_MDIV: begin
				if (dbit_q != 6'd0) begin
					drem_q <= rem_ge ? (rem_sh - dden_q) : rem_sh;
					dnum_q <= {dnum_q[NumW-2:0], rem_ge};
					dbit_q <= dbit_q - 1'b1;
				end else begin
					if (state_q == ST_DIV) begin
						vel_q[axis_q] <= qres;
					end else begin
						mean_q[axis_q] <= qres;
					end
					axis_q <= axis_q + 1'b1;
					if (state_q == ST_MDIV && axis_q != 2'd2) begin
						dnum_q <= NumW'(sum_mag_next(sum_q[axis_q + 1'b1])) +
							NumW'(count_q >> 1);
						dneg_q <= sum_q[axis_q + 1'b1][SumW-1];
						drem_q <= '0;
						dbit_q <= 6'(NumW);
					end
				end
			end
			ST_PUSH: begin
				walk_q <= (count_q == CntW'(HistDepth)) ?
					HistAw'((CntW+1)'(head_q) + 1'b1) : head_q;
			end
			ST_EVCHK: begin
				if (too_old) begin
					walk_q <= HistAw'((CntW+1)'(walk_q) + 1'b1);
				end else begin
					walk_cnt_q <= count_q;
					sum_q[0] <= '0;
					sum_q[1] <= '0;
					sum_q[2] <= '0;
				end
			end
			ST_SUMACC: begin
				sum_q[0] <= sum_q[0] + SumW'(signed'(ram_rdata[63:32]));
				sum_q[1] <= sum_q[1] + SumW'(signed'(ram_rdata[95:64]));
				sum_q[2] <= sum_q[2] + SumW'(signed'(ram_rdata[127:96]));
				walk_q <= HistAw'((CntW+1)'(walk_q) + 1'b1);
				walk_cnt_q <= walk_cnt_q - 1'b1;
				if (walk_cnt_q == CntW'(1)) begin
					axis_q <= 2'd0;
					dnum_q <= NumW'(sum_mag_next(sum_q[0] + SumW'(signed'(ram_rdata[63:32]))))
						+ NumW'(count_q >> 1);
					dneg_q <= sum_neg_next(sum_q[0] + SumW'(signed'(ram_rdata[63:32])));
					dden_q <= NumW'(count_q);
					drem_q <= '0;
					dbit_q <= 6'(NumW);
				end
			end
			ST_OUT: begin
				if (out_load) begin
					out_q <= {mean_q[2], mean_q[1], mean_q[0], pos_q[2], pos_q[1], pos_q[0],
						stamp_q};
				end
			end
			default: ;
		endcase
	end
endmodule

@@ hdl/wve_checker.sv @@
// ----------------------------------------------------------------------------
// wve_checker: port-level checks of the windowed velocity estimator
// Watches the handshakes of the top level over time.
// ----------------------------------------------------------------------------
module wve_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_ready,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [223:0] m_axis_tdata
);
	// A word waiting on the output holds until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	// No result word is offered while reset is held.
	assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// Samples and window writes are both taken only while the sequencer idles.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> cfg_ready)
		else $error("input ready while window write is refused");

	// A result word only follows a busy period, never straight from an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result appeared one cycle after accept");

	// An offered word carries known data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tdata))
		else $error("output word has unknown bits");
endmodule

bind windowed_velocity_estimator wve_checker u_wve_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cfg_ready     (cfg_ready),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ test/wve_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wve_scoreboard: result predictor and scoreboard for the velocity estimator
// Watches the window register channel and both streams, predicts the result
// word of every accepted sample that yields one, compares it field by field.
// ----------------------------------------------------------------------------
module wve_scoreboard (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // stamp_us, pos_x, pos_y, pos_z
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [223:0] m_axis_tdata,  // out_stamp_us, out_pos_x/y/z, vel_x/y/z
	output int           errors,
	output int           pending
);

	import wve_pkg::*;

	typedef struct {
		logic [31:0]        stamp;
		logic signed [31:0] px, py, pz;
		logic signed [31:0] vx, vy, vz;
	} pose_result_t;

	pose_result_t       expected_poses[$];
	logic [31:0]        window_us;
	logic [31:0]        ring_stamp[HistDepth];
	logic signed [31:0] ring_vx[HistDepth], ring_vy[HistDepth], ring_vz[HistDepth];
	int                 ring_head, ring_count;
	logic signed [31:0] last_x, last_y, last_z;
	logic [31:0]        last_stamp;

	// Rounds to nearest, ties away from zero.
	function automatic longint rounded_quotient(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic push_velocity(logic [31:0] st, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] vz);
		int slot;
		if (ring_count >= HistDepth) begin
			ring_head = (ring_head + 1) % HistDepth;
			ring_count--;
		end
		slot = (ring_head + ring_count) % HistDepth;
		ring_stamp[slot] = st;
		ring_vx[slot] = vx;
		ring_vy[slot] = vy;
		ring_vz[slot] = vz;
		ring_count++;
	endtask

	task automatic predict_pose(logic [127:0] word);
		logic [31:0]        st;
		logic signed [31:0] px, py, pz, dt, age;
		logic signed [31:0] vx, vy, vz;
		longint             sx, sy, sz;
		pose_result_t       r;
		st = word[31:0];
		px = word[63:32];
		py = word[95:64];
		pz = word[127:96];
		if (ring_count == 0) begin
			push_velocity(st, 0, 0, 0);
			last_x = px; last_y = py; last_z = pz; last_stamp = st;
			return;
		end
		dt = st - last_stamp;
		if (dt <= 0) return;
		vx = clamp32(rounded_quotient((longint'(px) - longint'(last_x)) * 1000000, longint'(dt)));
		vy = clamp32(rounded_quotient((longint'(py) - longint'(last_y)) * 1000000, longint'(dt)));
		vz = clamp32(rounded_quotient((longint'(pz) - longint'(last_z)) * 1000000, longint'(dt)));
		push_velocity(st, vx, vy, vz);
		last_x = px; last_y = py; last_z = pz; last_stamp = st;
		while (ring_count > 0) begin
			age = st - ring_stamp[ring_head];
			if (longint'(age) > longint'({32'b0, window_us})) begin
				ring_head = (ring_head + 1) % HistDepth;
				ring_count--;
			end else begin
				break;
			end
		end
		sx = 0; sy = 0; sz = 0;
		for (int i = 0; i < ring_count; i++) begin
			sx += ring_vx[(ring_head + i) % HistDepth];
			sy += ring_vy[(ring_head + i) % HistDepth];
			sz += ring_vz[(ring_head + i) % HistDepth];
		end
		r.stamp = st; r.px = px; r.py = py; r.pz = pz;
		r.vx = clamp32(rounded_quotient(sx, ring_count));
		r.vy = clamp32(rounded_quotient(sy, ring_count));
		r.vz = clamp32(rounded_quotient(sz, ring_count));
		expected_poses = {expected_poses, r};
	endtask

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic check_pose(logic [223:0] word);
		pose_result_t e;
		if (expected_poses.size() == 0) begin
			$error("result word %h arrived with none expected", word);
			errors++;
			return;
		end
		e = expected_poses.pop_front();
		compare_field("out_stamp_us", e.stamp, word[31:0]);
		compare_field("out_pos_x", e.px, word[63:32]);
		compare_field("out_pos_y", e.py, word[95:64]);
		compare_field("out_pos_z", e.pz, word[127:96]);
		compare_field("vel_x", e.vx, word[159:128]);
		compare_field("vel_y", e.vy, word[191:160]);
		compare_field("vel_z", e.vz, word[223:192]);
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_us = WindowReset;
			ring_head = 0;
			ring_count = 0;
			last_x = 0; last_y = 0; last_z = 0;
			last_stamp = 0;
			expected_poses.delete();
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) check_pose(m_axis_tdata);
			if (cfg_valid && cfg_ready) window_us = cfg_data;
			if (s_axis_tvalid && s_axis_tready) predict_pose(s_axis_tdata);
			pending = expected_poses.size();
		end
	end

endmodule

@@ test/windowed_velocity_estimator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_velocity_estimator_tb: stimulus and verdict for the estimator
// Drives directed edge cases and random pose tracks across several window
// settings, with random stalls on both streams; a scoreboard scores results.
// ----------------------------------------------------------------------------
module windowed_velocity_estimator_tb;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [223:0] m_axis_tdata;
	int           errors;
	int           pending;

	bit           calm;
	bit           hold_go;
	bit           hold_used;
	int           hold_left;
	logic [31:0]  cur_stamp;
	logic [31:0]  cur_x, cur_y, cur_z;

	windowed_velocity_estimator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	wve_scoreboard scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		hold_left = 0;
		hold_used = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pose(logic [31:0] st, logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		if (!calm && $urandom_range(99) < 19) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pz, py, px, st};
		#1;
		while (!s_axis_tready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
	endtask

	task automatic drain_results;
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		// Dropped samples give no word, so allow the block to finish one.
		repeat (600) @(negedge clk);
	endtask

	task automatic write_window(logic [31:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		#1;
		while (!cfg_ready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] next_axis(logic [31:0] p);
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) return $urandom;
		if (pick < 20) return p + $urandom_range(0, 32'h00ffffff) - 32'h007fffff;
		return p + $urandom_range(0, 32'h0001ffff) - 32'h00010000;
	endfunction

	task automatic random_track(int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 55) cur_stamp = cur_stamp + $urandom_range(1, 60000);
			else if (pick < 65) cur_stamp = cur_stamp + $urandom_range(1, 1000);
			else if (pick < 73) cur_stamp = cur_stamp - $urandom_range(0, 5000);
			else if (pick < 80) cur_stamp = cur_stamp + $urandom_range(1, 32'h7fffffff);
			else if (pick < 85) cur_stamp = $urandom;
			else cur_stamp = cur_stamp + $urandom_range(50000, 200000);
			cur_x = next_axis(cur_x);
			cur_y = next_axis(cur_y);
			cur_z = next_axis(cur_z);
			send_pose(cur_stamp, cur_x, cur_y, cur_z);
		end
	endtask

	initial begin
		#40ms;
		$display("windowed_velocity_estimator_tb failed");
		$finish;
	end

	initial begin
		calm = 1'b0;
		hold_go = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cur_stamp = 32'h1000;
		cur_x = 0; cur_y = 0; cur_z = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: first sample, dropped steps, rounding ties, saturation, wrap.
		send_pose(32'h100, 32'h0, 32'h0, 32'h0);
		send_pose(32'h100, 32'h5, 32'h5, 32'h5);
		send_pose(32'h050, 32'h5, 32'h5, 32'h5);
		send_pose(32'h100 + 2000000, 32'd1, 32'hffffffff, 32'd3);
		send_pose(32'h100 + 2000001, 32'h7fffffff, 32'h80000000, 32'h0);
		send_pose(32'h100 + 2000002, 32'h80000000, 32'h7fffffff, 32'hffffffff);
		send_pose(32'h100 + 2000003, 32'h80000000, 32'h7fffffff, 32'hffffffff);
		send_pose(32'h7fffffff + 32'h100 + 2000003, 32'haaaaaaaa, 32'h55555555, 32'h0);
		send_pose(32'h80000000 + 32'h7fffffff + 32'h100 + 2000003, 32'h1, 32'h2, 32'h3);
		send_pose(32'hfffffff0, 32'h00010000, 32'hffff0000, 32'h00008000);
		send_pose(32'h00000010, 32'h00020000, 32'hfffe0000, 32'h00008000);
		send_pose(32'h00000020, 32'h00020010, 32'hfffe0010, 32'h00008001);
		send_pose(32'h00000030, 32'h00020020, 32'hfffe0020, 32'h00008002);
		send_pose(32'h00000040, 32'h55555555, 32'haaaaaaaa, 32'h7fffffff);
		cur_stamp = 32'h40;
		cur_x = 32'h55555555; cur_y = 32'haaaaaaaa; cur_z = 32'h7fffffff;

		write_window(32'd0);
		random_track(120);

		write_window(32'hffffffff);
		hold_go = 1'b1;
		random_track(140);

		write_window(32'd5000);
		calm = 1'b1;
		random_track(100);
		calm = 1'b0;

		write_window($urandom);
		random_track(100);

		write_window(32'd1);
		random_track(76);

		write_window(32'd100000);
		random_track(100);

		drain_results();
		if (errors == 0) begin
			$display("windowed_velocity_estimator_tb passed");
		end else begin
			$display("windowed_velocity_estimator_tb failed");
		end
		$finish;
	end

endmodule
